// ===== src/chained_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// chained block allocator assertion macros
// shared concurrent assertion forms for the allocator checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_ALLOCATOR_MACROS_SVH
`define CHAINED_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// types, codes and default sizes of the chained block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  // default sizes
  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_BLOCK_BYTES = 128;
  localparam int DEF_NAME_BYTES  = 8;

  // fixed field widths
  localparam int OWNER_W  = 8;
  localparam int NAME_W   = 64;
  localparam int SIZE_W   = 16;
  localparam int ACCESS_W = 4;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 4;
  localparam int FREE_W   = 5;
  localparam int SEQ_W    = 4;
  localparam int LINK_W   = 5;

  // end of chain mark
  localparam logic [LINK_W-1:0] LINK_END = '1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_CREATED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SIZE_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_e;

endpackage

// ===== src/chained_block_allocator.sv =====
// ----------------------------------------------------------------------------
// chained block allocator
// takes create requests, allocates free table entries lowest index first
// and links them into a chain; the table lives in a one-port-read memory
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  request | in        | in_valid_i / in_stall_o | owner_id, file_name, file_size,
//          |           |                         | access_bits
//  result  | out       | out_valid_o/out_stall_i | status, first_entry, free_left
//
//  a rejected request goes from the check step straight to the result; a
//  created one is scanned first: the scan reads one table entry per cycle from
//  the entry memory, lowest index first, and stops after the last block
//  reset frees every entry at once through per-entry valid flops; no sweep
//  a new request is taken while a result waits in the output register; a
//  stalled result holds the sequencer only at its final step
module chained_block_allocator
  import cba_pkg::*;
#(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OWNER_W-1:0]  owner_id_i,
  input  logic [NAME_W-1:0]   file_name_i,
  input  logic [SIZE_W-1:0]   file_size_i,
  input  logic [ACCESS_W-1:0] access_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIRST_W-1:0]  first_entry_o,
  output logic [FREE_W-1:0]   free_left_o
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
  localparam int PROD_W  = CNT_W + BB_W;
  localparam int CMP_W   = (PROD_W > SIZE_W) ? PROD_W : SIZE_W + 1;
  localparam int STORE_W = 8 * NAME_BYTES;
  localparam int ENTRY_W = 1 + OWNER_W + STORE_W + ACCESS_W + SEQ_W + LINK_W;
  localparam int USED_BIT = ENTRY_W - 1;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [SIZE_W:0]   BB_CMP   = (SIZE_W + 1)'(BLOCK_BYTES);
  localparam logic [SIZE_W-1:0] BB_SUB   = SIZE_W'(BLOCK_BYTES);

  // sequencer and control state
  state_e              state_q, state_d;
  logic [IDX_W-1:0]    eval_idx_q, eval_idx_d;
  logic                pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic                out_valid_q, out_valid_d;

  // request and scan payload
  logic [OWNER_W-1:0]  owner_q, owner_d;
  logic [STORE_W-1:0]  name_q, name_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [ACCESS_W-1:0] access_q, access_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [SEQ_W-1:0]    pend_seq_q, pend_seq_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;

  // output register
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [FIRST_W-1:0]  out_first_q, out_first_d;
  logic [FREE_W-1:0]   out_free_q, out_free_d;

  // entry memory
  logic [ENTRY_W-1:0]  mem_q [ENTRIES];
  logic [ENTRY_W-1:0]  rd_data_q;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [LINK_W-1:0]   wr_link;
  logic [ENTRY_W-1:0]  wr_data;

  logic [CMP_W-1:0]    capacity;
  logic                entry_used;
  logic                out_free_slot;

  // bytes that the free entries can still hold
  assign capacity = CMP_W'(free_q) * CMP_W'(BLOCK_BYTES);

  // an entry never written since reset reads as free
  assign entry_used = valid_q[eval_idx_q] & rd_data_q[USED_BIT];

  assign out_free_slot = !out_valid_q || !out_stall_i;

  assign wr_data = {1'b1, owner_q, name_q, access_q, pend_seq_q, wr_link};

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    eval_idx_d   = eval_idx_q;
    pend_valid_d = pend_valid_q;
    free_d       = free_q;
    valid_d      = valid_q;
    owner_d      = owner_q;
    name_d       = name_q;
    rem_d        = rem_q;
    access_d     = access_q;
    status_d     = status_q;
    head_d       = head_q;
    pend_idx_d   = pend_idx_q;
    pend_seq_d   = pend_seq_q;
    seq_d        = seq_q;
    out_status_d = out_status_q;
    out_first_d  = out_first_q;
    out_free_d   = out_free_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rd_en        = 1'b0;
    rd_addr      = eval_idx_q;
    wr_en        = 1'b0;
    wr_addr      = pend_idx_q;
    wr_link      = LINK_END;
    in_stall_o   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          owner_d  = owner_id_i;
          name_d   = file_name_i[STORE_W-1:0];
          rem_d    = file_size_i;
          access_d = access_bits_i;
          state_d  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        head_d       = '0;
        seq_d        = '0;
        pend_valid_d = 1'b0;
        eval_idx_d   = '0;
        if (rem_q == '0) begin
          status_d = STATUS_SIZE_ZERO;
          state_d  = ST_FINISH;
        end else if (CMP_W'(rem_q) > capacity) begin
          status_d = STATUS_NO_SPACE;
          state_d  = ST_FINISH;
        end else begin
          // start the scan at entry zero
          status_d = STATUS_CREATED;
          rd_en    = 1'b1;
          rd_addr  = '0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // prefetch the following entry
        if (eval_idx_q != LAST_IDX) begin
          rd_en      = 1'b1;
          rd_addr    = eval_idx_q + 1'b1;
          eval_idx_d = eval_idx_q + 1'b1;
        end
        if (!entry_used) begin
          // close the previous link with this index
          if (pend_valid_q) begin
            wr_en            = 1'b1;
            wr_link          = LINK_W'(eval_idx_q);
            valid_d[pend_idx_q] = 1'b1;
          end else begin
            head_d = eval_idx_q;
          end
          pend_valid_d = 1'b1;
          pend_idx_d   = eval_idx_q;
          pend_seq_d   = seq_q;
          seq_d        = seq_q + 1'b1;
          free_d       = free_q - 1'b1;
          rem_d        = rem_q - BB_SUB;
          if ({1'b0, rem_q} <= BB_CMP) begin
            state_d = ST_FLUSH;
          end
        end
        if (eval_idx_q == LAST_IDX) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // write the tail of the chain
        if (pend_valid_q) begin
          wr_en               = 1'b1;
          valid_d[pend_idx_q] = 1'b1;
        end
        pend_valid_d = 1'b0;
        state_d      = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free_slot) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_first_d  = FIRST_W'(head_q);
          out_free_d   = FREE_W'(free_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_idx_q   <= '0;
      pend_valid_q <= 1'b0;
      free_q       <= CNT_W'(ENTRIES);
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      eval_idx_q   <= eval_idx_d;
      pend_valid_q <= pend_valid_d;
      free_q       <= free_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    owner_q      <= owner_d;
    name_q       <= name_d;
    rem_q        <= rem_d;
    access_q     <= access_d;
    status_q     <= status_d;
    head_q       <= head_d;
    pend_idx_q   <= pend_idx_d;
    pend_seq_q   <= pend_seq_d;
    seq_q        <= seq_d;
    out_status_q <= out_status_d;
    out_first_q  <= out_first_d;
    out_free_q   <= out_free_d;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign first_entry_o = out_first_q;
  assign free_left_o   = out_free_q;

endmodule

// ===== src/cba_checker.sv =====
// ----------------------------------------------------------------------------
// cba_checker
// port-level checks of the chained block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "chained_block_allocator_macros.svh"

module cba_checker
  import cba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [FIRST_W-1:0]  first_entry_o,
  input logic [FREE_W-1:0]   free_left_o
);

  // a stalled result holds its value
  `CBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(first_entry_o) && $stable(free_left_o), "stalled result changed")

  // one request at a time: busy right after an accepted transaction
  `CBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  // a rejected request names no head entry
  `CBA_ASSERT_IMPLY(a_reject_head, clk_i, rst_ni, out_valid_o && (status_o != STATUS_CREATED), first_entry_o == '0, "rejected request with head entry")

  // a new result only comes out of a request in progress
  `CBA_ASSERT_IMPLY(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without request")

endmodule

bind chained_block_allocator cba_checker u_cba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .first_entry_o (first_entry_o),
  .free_left_o   (free_left_o)
);

// ===== test/chained_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// chained block allocator testbench
// drives create requests through the request channel, predicts status, head
// entry and free count from a private copy of the block table, and compares
// every result transaction in order while both sides idle at random
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// one expected result transaction
typedef struct packed {
  logic [cba_pkg::STATUS_W-1:0] status;
  logic [cba_pkg::FIRST_W-1:0]  first_entry;
  logic [cba_pkg::FREE_W-1:0]   free_left;
} alloc_result_t;

// one table entry as the allocator keeps it
typedef struct {
  bit                           used;
  logic [cba_pkg::OWNER_W-1:0]  owner;
  logic [cba_pkg::NAME_W-1:0]   name;
  logic [cba_pkg::ACCESS_W-1:0] access;
  logic [cba_pkg::SEQ_W-1:0]    seq;
  logic [cba_pkg::LINK_W-1:0]   link;
} alloc_entry_t;

class alloc_scoreboard;
  alloc_entry_t  block_table[cba_pkg::DEF_ENTRIES];
  int            free_count;
  alloc_result_t pending_results[$];
  int            mismatch_count;
  int            result_index;

  function new();
    foreach (block_table[i]) begin
      block_table[i].used   = 1'b0;
      block_table[i].owner  = '0;
      block_table[i].name   = '0;
      block_table[i].access = '0;
      block_table[i].seq    = '0;
      block_table[i].link   = cba_pkg::LINK_END;
    end
    free_count     = cba_pkg::DEF_ENTRIES;
    mismatch_count = 0;
    result_index   = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  task report(string what);
    $display("[%0t] error: %s", $time, what);
    mismatch_count++;
  endtask

  // allocate in the private table and queue the expected result
  function void note_request(logic [cba_pkg::OWNER_W-1:0]  owner,
                             logic [cba_pkg::NAME_W-1:0]   name,
                             logic [cba_pkg::SIZE_W-1:0]   size,
                             logic [cba_pkg::ACCESS_W-1:0] access);
    alloc_result_t            res;
    int                       blocks_needed;
    int                       taken;
    int                       prev;
    logic [cba_pkg::NAME_W-1:0] kept_name;
    res       = '0;
    taken     = 0;
    prev      = 0;
    kept_name = (cba_pkg::DEF_NAME_BYTES >= 8) ? name
              : name & ((64'd1 << (8 * cba_pkg::DEF_NAME_BYTES)) - 64'd1);
    if (size == '0) begin
      res.status = cba_pkg::STATUS_SIZE_ZERO;
    end else begin
      blocks_needed = (int'(size) + cba_pkg::DEF_BLOCK_BYTES - 1) / cba_pkg::DEF_BLOCK_BYTES;
      if (blocks_needed > free_count) begin
        res.status = cba_pkg::STATUS_NO_SPACE;
      end else begin
        res.status = cba_pkg::STATUS_CREATED;
        for (int i = 0; i < cba_pkg::DEF_ENTRIES && taken < blocks_needed; i++) begin
          if (!block_table[i].used) begin
            block_table[i].used   = 1'b1;
            block_table[i].owner  = owner;
            block_table[i].name   = kept_name;
            block_table[i].access = access;
            block_table[i].seq    = taken[cba_pkg::SEQ_W-1:0];
            block_table[i].link   = cba_pkg::LINK_END;
            if (taken == 0) res.first_entry = i[cba_pkg::FIRST_W-1:0];
            else block_table[prev].link = i[cba_pkg::LINK_W-1:0];
            prev = i;
            taken++;
          end
        end
        free_count -= taken;
      end
    end
    res.free_left = free_count[cba_pkg::FREE_W-1:0];
    pending_results.push_back(res);
  endfunction

  // compare one result transaction with the oldest expectation
  task check_result(logic [cba_pkg::STATUS_W-1:0] status,
                    logic [cba_pkg::FIRST_W-1:0]  first_entry,
                    logic [cba_pkg::FREE_W-1:0]   free_left);
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", result_index));
    end else begin
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d",
                         result_index, status, want.status));
      if (first_entry !== want.first_entry)
        report($sformatf("result %0d first_entry %0d, expected %0d",
                         result_index, first_entry, want.first_entry));
      if (free_left !== want.free_left)
        report($sformatf("result %0d free_left %0d, expected %0d",
                         result_index, free_left, want.free_left));
    end
    result_index++;
  endtask
endclass

module chained_block_allocator_test;
  import cba_pkg::*;

  localparam int RANDOM_PER_PHASE = 475;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [OWNER_W-1:0]  owner_id_i    = '0;
  logic [NAME_W-1:0]   file_name_i   = '0;
  logic [SIZE_W-1:0]   file_size_i   = '0;
  logic [ACCESS_W-1:0] access_bits_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [FIRST_W-1:0]  first_entry_o;
  logic [FREE_W-1:0]   free_left_o;

  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  alloc_scoreboard alloc_sb       = new();

  chained_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .owner_id_i    (owner_id_i),
    .file_name_i   (file_name_i),
    .file_size_i   (file_size_i),
    .access_bits_i (access_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .first_entry_o (first_entry_o),
    .free_left_o   (free_left_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // result side: check accepted transactions, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) alloc_sb.check_result(status_o, first_entry_o, free_left_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // request side: optional idle cycles, then hold the transaction until taken
  task send_request(logic [OWNER_W-1:0]  owner,
                    logic [NAME_W-1:0]   name,
                    logic [SIZE_W-1:0]   size,
                    logic [ACCESS_W-1:0] access);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    owner_id_i    <= owner;
    file_name_i   <= name;
    file_size_i   <= size;
    access_bits_i <= access;
    do @(posedge clk_i); while (in_stall_o);
    alloc_sb.note_request(owner, name, size, access);
  endtask

  // sizes weighted toward few blocks, block boundaries and oversize requests
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return SIZE_W'($urandom_range(256, 1));
      4, 5:    return SIZE_W'($urandom_range(DEF_ENTRIES * DEF_BLOCK_BYTES, 257));
      6:       return SIZE_W'(DEF_BLOCK_BYTES * $urandom_range(DEF_ENTRIES, 1));
      7:       return SIZE_W'($urandom_range(65535, DEF_ENTRIES * DEF_BLOCK_BYTES + 1));
      8:       return $urandom_range(1) ? '1 : SIZE_W'(1);
      default: return SIZE_W'($urandom());
    endcase
  endfunction

  task send_random(int count);
    for (int n = 0; n < count; n++)
      send_request(OWNER_W'($urandom_range(255)), {$urandom(), $urandom()},
                   pick_size(), ACCESS_W'($urandom_range(15)));
  endtask

  // hold the request side until every result is back
  task drain_results();
    in_valid_i <= 1'b0;
    while (alloc_sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejections on an empty table, then chains with rejections between until full
    send_request(8'h00, 64'h0, 16'd0, 4'h0);
    send_request(8'hFF, '1, 16'hFFFF, 4'hF);
    send_request(8'h12, 64'h0068_6374_6170_7365, 16'd2049, 4'h5);
    send_request(8'hFF, '1, 16'd128, 4'hF);
    send_request(8'h00, 64'h0, 16'd1, 4'h0);
    send_request(8'hA5, 64'h5A5A_A5A5_0F0F_F0F0, 16'd129, 4'hA);
    send_request(8'h5A, 64'hA5A5_5A5A_F0F0_0F0F, 16'd256, 4'h5);
    send_request(8'h01, 64'h1, 16'd1281, 4'h1);
    send_request(8'h80, 64'h8000_0000_0000_0000, 16'd1152, 4'h8);
    send_request(8'h7F, 64'h7FFF_FFFF_FFFF_FFFF, 16'd129, 4'h7);
    send_request(8'h03, 64'h3, 16'd0, 4'h3);
    send_request(8'hFE, 64'hFFFF_FFFF_FFFF_FFFE, 16'd128, 4'hE);
    send_request(8'h33, 64'h3333_3333_3333_3333, 16'd1, 4'hC);
    drain_results();

    // random phases: no idling, sender idle, receiver stalling, both
    send_random(RANDOM_PER_PHASE);
    drain_results();
    send_idle_pct = 59;
    send_random(RANDOM_PER_PHASE);
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    send_random(RANDOM_PER_PHASE);
    drain_results();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_random(RANDOM_PER_PHASE);
    drain_results();

    // allow a late extra result to show up
    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (alloc_sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cba_pkg.sv
src/chained_block_allocator.sv
src/cba_checker.sv
test/chained_block_allocator_test.sv
